// ----- rtl/core/fpa_pkg.sv -----
// Package for the fixed-point ALU: operation codes, transaction structs and
// the record handed along the divider cell chain. No dependencies.
`timescale 1ns / 1ps
package fpa_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_MAX  = 30;
  localparam int FRAC_DEF  = 8;
  localparam int DVD_W     = DATA_W + FRAC_MAX;

  localparam logic [3:0] OP_ADD     = 4'd0;
  localparam logic [3:0] OP_SUB     = 4'd1;
  localparam logic [3:0] OP_MUL     = 4'd2;
  localparam logic [3:0] OP_DIV     = 4'd3;
  localparam logic [3:0] OP_MIN     = 4'd4;
  localparam logic [3:0] OP_MAX     = 4'd5;
  localparam logic [3:0] OP_INC     = 4'd6;
  localparam logic [3:0] OP_DEC     = 4'd7;
  localparam logic [3:0] OP_FROMINT = 4'd8;
  localparam logic [3:0] OP_TOINT   = 4'd9;

  typedef struct packed {
    logic [3:0]               kind;
    logic signed [DATA_W-1:0] a_raw;
    logic signed [DATA_W-1:0] b_raw;
  } in_data_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_raw;
    logic                     a_greater;
    logic                     a_less;
    logic                     a_equal;
    logic                     divide_by_zero;
  } out_data_t;

  // one divider cell's record
  typedef struct packed {
    logic              valid;
    logic              is_div;
    logic              neg;
    logic [DATA_W-1:0] res;
    logic [2:0]        flags;
    logic              dz;
    logic [DATA_W-1:0] dvs;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] quo;
    logic [DVD_W-1:0]  dvd;
  } cell_t;

endpackage

// ----- rtl/core/fpa_div_cell.sv -----
// One restoring-division cell: resolves one quotient bit per transaction and
// hands the record to the next cell. Depends on fpa_pkg.
`timescale 1ns / 1ps
module fpa_div_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  fpa_pkg::cell_t cell_in,
  output fpa_pkg::cell_t cell_out
);
  import fpa_pkg::*;

  cell_t             cell_r;
  cell_t             cell_nxt;
  logic [DATA_W:0]   trial;
  logic              ge;

  always_comb begin
    trial          = {cell_in.rem, cell_in.dvd[DVD_W-1]};
    ge             = trial >= {1'b0, cell_in.dvs};
    cell_nxt       = cell_in;
    cell_nxt.rem   = ge ? DATA_W'(trial - {1'b0, cell_in.dvs}) : trial[DATA_W-1:0];
    cell_nxt.quo   = {cell_in.quo[DATA_W-2:0], ge};
    cell_nxt.dvd   = {cell_in.dvd[DVD_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;

endmodule

// ----- rtl/core/fixed_point_alu.sv -----
// Top level of the signed fixed-point ALU: operand/multiply stage, a chain of
// divider cells, output register. Depends on fpa_pkg and fpa_div_cell.
//
//  channel | ports                           | payload
//  input   | in_valid, in_ready, in_data     | fpa_pkg::in_data_t
//  output  | out_valid, out_ready, out_data  | fpa_pkg::out_data_t
//
// One transaction per cycle unless the output stalls; every operation passes
// the operand stage, the chain of 32 + FRAC_BITS divider cells (one quotient
// bit each) and the output register. Reset clears all valid bits. A stalled
// output freezes the whole pipeline; in_ready = !out_valid || out_ready.
`timescale 1ns / 1ps
module fixed_point_alu #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fpa_pkg::in_data_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fpa_pkg::out_data_t out_data
);
  import fpa_pkg::*;

  localparam int NCELL = DATA_W + FRAC_BITS;
  localparam logic [2*DATA_W-1:0] RND64 = (64'(1) << FRAC_BITS) - 64'(1);
  localparam logic [DATA_W:0]     RND33 = (33'(1) << FRAC_BITS) - 33'(1);

  logic                       en;
  logic                       s1_valid_r;
  in_data_t                   s1_data_r;
  logic signed [2*DATA_W-1:0] s1_prod_r;
  cell_t                      chain [NCELL+1];
  cell_t                      head;
  logic signed [DATA_W-1:0]   a;
  logic signed [DATA_W-1:0]   b;
  logic signed [2*DATA_W-1:0] prod_adj;
  logic signed [DATA_W:0]     a_adj;
  logic [DATA_W-1:0]          res;
  logic                       out_valid_r;
  out_data_t                  out_data_r;
  out_data_t                  out_data_nxt;
  cell_t                      last;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
      s1_data_r  <= in_data;
      s1_prod_r  <= 64'(in_data.a_raw) * 64'(in_data.b_raw);
    end
  end

  always_comb begin
    a        = s1_data_r.a_raw;
    b        = s1_data_r.b_raw;
    prod_adj = (s1_prod_r + (s1_prod_r[2*DATA_W-1] ? RND64 : '0)) >>> FRAC_BITS;
    a_adj    = ($signed({a[DATA_W-1], a}) + $signed(a[DATA_W-1] ? RND33 : '0))
               >>> FRAC_BITS;
    case (s1_data_r.kind)
      OP_ADD:     res = a + b;
      OP_SUB:     res = a - b;
      OP_MUL:     res = prod_adj[DATA_W-1:0];
      OP_MIN:     res = (a <= b) ? a : b;
      OP_MAX:     res = (a >= b) ? a : b;
      OP_INC:     res = a + DATA_W'(1);
      OP_DEC:     res = a - DATA_W'(1);
      OP_FROMINT: res = a <<< FRAC_BITS;
      OP_TOINT:   res = a_adj[DATA_W-1:0];
      default:    res = '0;
    endcase
    head.valid  = s1_valid_r;
    head.is_div = s1_data_r.kind == OP_DIV;
    head.neg    = a[DATA_W-1] ^ b[DATA_W-1];
    head.res    = res;
    head.flags  = {a > b, a < b, a == b};
    head.dz     = (s1_data_r.kind == OP_DIV) && (b == '0);
    head.dvs    = b[DATA_W-1] ? DATA_W'(-b) : b;
    head.rem    = '0;
    head.quo    = '0;
    head.dvd    = {(a[DATA_W-1] ? DATA_W'(-a) : a), {FRAC_MAX{1'b0}}};
  end

  assign chain[0] = head;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    fpa_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .cell_in  (chain[i]),
      .cell_out (chain[i+1])
    );
  end

  always_comb begin
    last                         = chain[NCELL];
    out_data_nxt.a_greater       = last.flags[2];
    out_data_nxt.a_less          = last.flags[1];
    out_data_nxt.a_equal         = last.flags[0];
    out_data_nxt.divide_by_zero  = last.dz;
    if (!last.is_div) begin
      out_data_nxt.result_raw = last.res;
    end else if (last.dz) begin
      out_data_nxt.result_raw = '0;
    end else begin
      out_data_nxt.result_raw = last.neg ? DATA_W'(-last.quo) : last.quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= last.valid;
      out_data_r  <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_data.a_greater, out_data.a_less, out_data.a_equal}))
    else $error("comparison flags not one-hot");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.divide_by_zero |-> out_data.result_raw == '0)
    else $error("divide by zero with nonzero result");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data) && !$past(in_ready))
    else $error("output changed while stalled");

endmodule

// ----- tb/fixed_point_alu_test.sv -----
// Self-checking testbench for fixed_point_alu: directed and random operations
// are checked against a behavioral prediction. Depends on fpa_pkg and the RTL.
`timescale 1ns / 1ps
module fixed_point_alu_test;
  import fpa_pkg::*;

  localparam int FRAC = FRAC_DEF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_data_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_data_t out_data;

  in_data_t pending_ops[$];
  out_data_t expected_results[$];
  int errors = 0;
  bit stim_done = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;

  fixed_point_alu #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #2 clk = ~clk;

  function automatic out_data_t alu_predict(in_data_t op);
    out_data_t r;
    logic signed [63:0] a, b, t;
    a = op.a_raw;
    b = op.b_raw;
    r = '0;
    case (op.kind)
      OP_ADD: r.result_raw = op.a_raw + op.b_raw;
      OP_SUB: r.result_raw = op.a_raw - op.b_raw;
      OP_MUL: begin
        t = (a * b) / (64'sd1 <<< FRAC);
        r.result_raw = t[31:0];
      end
      OP_DIV: begin
        if (b == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          t = (a * (64'sd1 <<< FRAC)) / b;
          r.result_raw = t[31:0];
        end
      end
      OP_MIN: r.result_raw = (a <= b) ? op.a_raw : op.b_raw;
      OP_MAX: r.result_raw = (a >= b) ? op.a_raw : op.b_raw;
      OP_INC: r.result_raw = op.a_raw + 32'sd1;
      OP_DEC: r.result_raw = op.a_raw - 32'sd1;
      OP_FROMINT: begin
        t = a * (64'sd1 <<< FRAC);
        r.result_raw = t[31:0];
      end
      OP_TOINT: begin
        t = a / (64'sd1 <<< FRAC);
        r.result_raw = t[31:0];
      end
      default: r.result_raw = '0;
    endcase
    r.a_greater = a > b;
    r.a_less = a < b;
    r.a_equal = a == b;
    return r;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7fff_ffff - $urandom_range(0, 3);
      2: return $urandom_range(0, 4) - 2;
      3: return $urandom_range(0, 4095) - 2048;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_op(logic [3:0] k, logic [31:0] a, logic [31:0] b);
    in_data_t op;
    op.kind = k;
    op.a_raw = a;
    op.b_raw = b;
    pending_ops.push_back(op);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(alu_predict(in_data));
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          in_data <= pending_ops.pop_front();
          in_valid <= 1'b1;
          send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_data_t exp_r;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected transaction: result_raw %0d", out_data.result_raw);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.result_raw !== out_data.result_raw) begin
            $error("result_raw: expected %0d, got %0d", exp_r.result_raw,
                   out_data.result_raw);
            errors++;
          end
          if (exp_r.a_greater !== out_data.a_greater) begin
            $error("a_greater: expected %0b, got %0b", exp_r.a_greater,
                   out_data.a_greater);
            errors++;
          end
          if (exp_r.a_less !== out_data.a_less) begin
            $error("a_less: expected %0b, got %0b", exp_r.a_less, out_data.a_less);
            errors++;
          end
          if (exp_r.a_equal !== out_data.a_equal) begin
            $error("a_equal: expected %0b, got %0b", exp_r.a_equal, out_data.a_equal);
            errors++;
          end
          if (exp_r.divide_by_zero !== out_data.divide_by_zero) begin
            $error("divide_by_zero: expected %0b, got %0b", exp_r.divide_by_zero,
                   out_data.divide_by_zero);
            errors++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_valid && $urandom_range(0, 3) == 0) recv_gap <= $urandom_range(0, 18);
      end
    end
  end

  initial begin
    int n;
    add_op(OP_ADD, 32'h7fff_ffff, 32'h0000_0001);
    add_op(OP_SUB, 32'h8000_0000, 32'h0000_0001);
    add_op(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
    add_op(OP_MUL, 32'h8000_0000, 32'hffff_ffff);
    add_op(OP_MUL, 32'hffff_ff80, 32'h0000_0001);
    add_op(OP_DIV, 32'h0000_0100, 32'h0000_0000);
    add_op(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    add_op(OP_DIV, 32'hffff_fd00, 32'h0000_0700);
    add_op(OP_DIV, 32'h7fff_ffff, 32'h0000_0001);
    add_op(OP_MIN, 32'h8000_0000, 32'h7fff_ffff);
    add_op(OP_MAX, 32'h8000_0000, 32'h7fff_ffff);
    add_op(OP_MIN, 32'h0000_0005, 32'h0000_0005);
    add_op(OP_INC, 32'h7fff_ffff, 32'h0000_0000);
    add_op(OP_DEC, 32'h8000_0000, 32'h0000_0000);
    add_op(OP_FROMINT, 32'h0080_0000, 32'h0000_0001);
    add_op(OP_FROMINT, 32'hff80_0001, 32'hffff_ffff);
    add_op(OP_TOINT, 32'hffff_ff01, 32'h0000_0000);
    add_op(OP_TOINT, 32'h8000_0000, 32'h7fff_ffff);
    add_op(4'd10, 32'h0000_0003, 32'h0000_0002);
    add_op(4'd15, 32'hffff_ffff, 32'hffff_ffff);
    add_op(OP_DIV, 32'h0000_0000, 32'h0000_0000);
    for (n = 0; n < 600; n++) begin
      add_op(($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
                                          : 4'($urandom_range(0, 9)),
             rand_operand(), rand_operand());
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_ops.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (4 * (34 + FRAC)) @(posedge clk);
    if (errors == 0) begin
      $display("** fixed_point_alu: PASSED **");
    end else begin
      $display("** fixed_point_alu: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** fixed_point_alu: FAILED **");
    $finish;
  end
endmodule
